[rtl/dlf_pkg.sv]
// Shared types, codes and activation tables for the dense layer forward block.
package dlf_pkg;

    localparam int CNT_W     = 5;
    localparam int NEURON_W  = 4;
    localparam int RES_LIMIT = 16;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;

    localparam logic [1:0] ACT_RELU    = 2'd0;
    localparam logic [1:0] ACT_SIGMOID = 2'd1;
    localparam logic [1:0] ACT_TANH    = 2'd2;

    localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
    localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
    localparam logic [1:0] CFG_ACT_MODE  = 2'd2;

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic [255:0][15:0] act_tab_t;

    typedef struct packed {
        logic                load;
        logic                rd;
        logic                mul;
        logic                acc;
        logic                bias;
        logic                acc_clr;
        logic                res_load;
        logic                last_neuron;
        logic [NEURON_W-1:0] neuron;
        logic [CNT_W-1:0]    step;
        logic [1:0]          act_mode;
    } cmd_t;

    // Unsigned restoring long division for building the tables.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] quo;
        logic [64:0] rem;
        int          k;
        quo = '0;
        rem = '0;
        for (k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, d})
            begin
                rem    = rem - {1'b0, d};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds the Q4.4-indexed sigmoid (sel 0) or tanh (sel 1) table at elaboration.
    // Entry idx holds the result for q equal to idx read as a signed byte.
    function automatic act_tab_t build_act_table(input logic tanh_sel);
        act_tab_t    tab;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] b;
        logic [63:0] pw [0:256];
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] res;
        int          k;
        int          idx;
        int          q;
        int          m;
        t   = 64'd1 << 40;
        sum = t;
        for (k = 1; k <= 12; k++)
        begin
            t = udiv64(t, 64'd16 * 64'(k));
            if (k[0])
                sum = sum - t;
            else
                sum = sum + t;
        end
        b = (sum + (64'd1 << 9)) >> 10;
        pw[0] = ONE_Q30;
        for (k = 1; k <= 256; k++)
        begin
            pw[k] = (pw[k-1] * b + (ONE_Q30 >> 1)) >> 30;
        end
        for (idx = 0; idx < 256; idx++)
        begin
            q = (idx < 128) ? idx : idx - 256;
            m = (q < 0) ? -q : q;
            if (!tanh_sel)
            begin
                e   = pw[m];
                den = ONE_Q30 + e;
                num = (q >= 0) ? (64'd256 * ONE_Q30) : (64'd256 * e);
                res = udiv64(64'd2 * num + den, 64'd2 * den);
            end
            else
            begin
                e   = pw[2 * m];
                den = ONE_Q30 + e;
                num = 64'd256 * (ONE_Q30 - e);
                res = udiv64(64'd2 * num + den, 64'd2 * den);
                if (q < 0)
                    res = -res;
            end
            tab[idx] = res[15:0];
        end
        return tab;
    endfunction

    localparam act_tab_t SIG_TAB  = build_act_table(1'b0);
    localparam act_tab_t TANH_TAB = build_act_table(1'b1);

    // Saturates a 33-bit signed sum to the 32-bit accumulator range.
    function automatic logic signed [31:0] sat_acc(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/dense_layer_forward.sv]
// Top level of the fully connected layer forward block.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  input    | in_valid / in_ready     | opcode, row, col, value, last
//  result   | out_valid / out_ready   | neuron, out_value, final_res
//  config   | cfg_we                  | cfg_index, cfg_data
//
// Load transfers are taken one per cycle while no pass is running.
// For each neuron a pass runs one MAC step per input (store read, multiply,
// accumulate), then a bias, an activation and a result state.
// The input is not ready during a pass; the pass pauses while a result waits.
// Reset clears control and configuration only; store entries are undefined
// until written, so there is no clearing pass.
module dense_layer_forward #(
    parameter int IN_MAX  = 16,
    parameter int OUT_MAX = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [3:0]                 row,
    input  logic [3:0]                 col,
    input  logic signed [15:0]         value,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3:0]                 neuron,
    output logic signed [15:0]         out_value,
    output logic                       final_res,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [dlf_pkg::CNT_W-1:0]  cfg_data
);

    dlf_pkg::cmd_t cmd;
    logic          pass_req;

    dlf_ctrl #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pass_req  (pass_req),
        .cmd       (cmd)
    );

    dlf_datapath #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .opcode    (opcode),
        .row       (row),
        .col       (col),
        .value     (value),
        .last      (last),
        .pass_req  (pass_req),
        .neuron    (neuron),
        .out_value (out_value),
        .final_res (final_res)
    );

endmodule

[rtl/dlf_ctrl.sv]
// Controller state machine: load acceptance, MAC sequencing and result hand-off.
module dlf_ctrl #(
    parameter int IN_MAX  = 16,
    parameter int OUT_MAX = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [dlf_pkg::CNT_W-1:0]  cfg_data,
    input  logic                       pass_req,
    output dlf_pkg::cmd_t              cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_BIAS = 7'b0010000,
        S_ACT  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    localparam logic [dlf_pkg::CNT_W-1:0] NI_CAP =
        (IN_MAX < 31) ? dlf_pkg::CNT_W'(IN_MAX) : 5'd31;
    localparam logic [dlf_pkg::CNT_W-1:0] NO_CAP =
        (OUT_MAX < dlf_pkg::RES_LIMIT) ? dlf_pkg::CNT_W'(OUT_MAX)
                                       : dlf_pkg::CNT_W'(dlf_pkg::RES_LIMIT);

    state_t                          state_reg, state_next;
    logic [dlf_pkg::NEURON_W-1:0]    i_reg, i_next;
    logic [dlf_pkg::CNT_W-1:0]       j_reg, j_next;
    logic [dlf_pkg::CNT_W-1:0]       in_count_reg;
    logic [dlf_pkg::CNT_W-1:0]       out_count_reg;
    logic [1:0]                      act_mode_reg;
    logic [dlf_pkg::CNT_W-1:0]       ni;
    logic [dlf_pkg::CNT_W-1:0]       no;
    logic [dlf_pkg::CNT_W-1:0]       ni_last;
    logic [dlf_pkg::NEURON_W-1:0]    no_last;
    logic [dlf_pkg::CNT_W-1:0]       no_m1;

    // A count of zero behaves as one; counts beyond the stores are capped.
    always_comb
    begin
        ni = (in_count_reg == '0) ? dlf_pkg::CNT_W'(1) : in_count_reg;
        if (ni > NI_CAP)
            ni = NI_CAP;
        no = (out_count_reg == '0) ? dlf_pkg::CNT_W'(1) : out_count_reg;
        if (no > NO_CAP)
            no = NO_CAP;
        ni_last = ni - dlf_pkg::CNT_W'(1);
        no_m1   = no - dlf_pkg::CNT_W'(1);
        no_last = no_m1[dlf_pkg::NEURON_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= dlf_pkg::CNT_W'(1);
            out_count_reg <= dlf_pkg::CNT_W'(1);
            act_mode_reg  <= dlf_pkg::ACT_RELU;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dlf_pkg::CFG_IN_COUNT:  in_count_reg  <= cfg_data;
                dlf_pkg::CFG_OUT_COUNT: out_count_reg <= cfg_data;
                dlf_pkg::CFG_ACT_MODE:  act_mode_reg  <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.neuron      = i_reg;
        cmd.step        = j_reg;
        cmd.act_mode    = act_mode_reg;
        cmd.last_neuron = (i_reg == no_last);
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && pass_req)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd      = 1'b1;
                cmd.acc_clr = (j_reg == '0);
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (j_reg == ni_last)
                    state_next = S_BIAS;
                else
                begin
                    j_next     = j_reg + dlf_pkg::CNT_W'(1);
                    state_next = S_READ;
                end
            end
            S_BIAS:
            begin
                cmd.bias   = 1'b1;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (i_reg == no_last)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + dlf_pkg::NEURON_W'(1);
                        j_next     = '0;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

[rtl/dlf_datapath.sv]
// Datapath: weight, bias and input stores, multiply-accumulate and activation.
module dlf_datapath #(
    parameter int IN_MAX  = 16,
    parameter int OUT_MAX = 16
) (
    input  logic                 clk,
    input  dlf_pkg::cmd_t        cmd,
    input  logic [1:0]           opcode,
    input  logic [3:0]           row,
    input  logic [3:0]           col,
    input  logic signed [15:0]   value,
    input  logic                 last,
    output logic                 pass_req,
    output logic [3:0]           neuron,
    output logic signed [15:0]   out_value,
    output logic                 final_res
);

    localparam int WDEPTH = OUT_MAX * IN_MAX;
    localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int XA     = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int BA     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

    logic signed [15:0] wmem [WDEPTH];
    logic signed [15:0] bmem [OUT_MAX];
    logic signed [15:0] xmem [IN_MAX];

    logic               w_we, b_we, x_we;
    logic [WA-1:0]      w_waddr, w_raddr;
    logic [BA-1:0]      b_waddr, b_raddr;
    logic [XA-1:0]      x_waddr, x_raddr;

    logic signed [15:0] w_rd_reg, x_rd_reg, b_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [32:0] addend;
    logic signed [32:0] sum;
    logic signed [23:0] s24;
    logic signed [15:0] s16;
    logic signed [11:0] q12;
    logic [7:0]         q8;
    logic signed [15:0] act_val;
    logic [3:0]         neuron_reg;
    logic signed [15:0] out_value_reg;
    logic               final_reg;

    assign pass_req = (opcode == dlf_pkg::OP_INPUT) && last;

    // Writes outside the store sizes set by the parameters are dropped.
    assign w_we = cmd.load && (opcode == dlf_pkg::OP_WEIGHT)
                  && (int'(row) < OUT_MAX) && (int'(col) < IN_MAX);
    assign b_we = cmd.load && (opcode == dlf_pkg::OP_BIAS) && (int'(row) < OUT_MAX);
    assign x_we = cmd.load && (opcode == dlf_pkg::OP_INPUT) && (int'(col) < IN_MAX);

    assign w_waddr = WA'(int'(row) * IN_MAX + int'(col));
    assign b_waddr = BA'(row);
    assign x_waddr = XA'(col);
    assign w_raddr = WA'(int'(cmd.neuron) * IN_MAX + int'(cmd.step));
    assign b_raddr = BA'(cmd.neuron);
    assign x_raddr = XA'(cmd.step);

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_waddr] <= value;
        if (cmd.rd)
            w_rd_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            bmem[b_waddr] <= value;
        if (cmd.rd)
            b_rd_reg <= bmem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            xmem[x_waddr] <= value;
        if (cmd.rd)
            x_rd_reg <= xmem[x_raddr];
    end

    // The bias joins the Q16.16 accumulator shifted up by eight bits.
    assign addend = cmd.bias ? {{9{b_rd_reg[15]}}, b_rd_reg, 8'b0}
                             : {prod_reg[31], prod_reg};
    assign sum    = {acc_reg[31], acc_reg} + addend;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= w_rd_reg * x_rd_reg;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc || cmd.bias)
            acc_reg <= dlf_pkg::sat_acc(sum);
    end

    always_comb
    begin
        s24 = acc_reg[31:8];
        if (s24 > 24'sd32767)
            s16 = 16'sh7FFF;
        else if (s24 < -24'sd32768)
            s16 = 16'sh8000;
        else
            s16 = s24[15:0];
        q12 = s16[15:4];
        if (q12 > 12'sd127)
            q8 = 8'h7F;
        else if (q12 < -12'sd128)
            q8 = 8'h80;
        else
            q8 = q12[7:0];
        case (cmd.act_mode)
            dlf_pkg::ACT_SIGMOID: act_val = dlf_pkg::SIG_TAB[q8];
            dlf_pkg::ACT_TANH:    act_val = dlf_pkg::TANH_TAB[q8];
            default:              act_val = (s16 > 16'sd0) ? s16 : 16'sd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            neuron_reg    <= cmd.neuron;
            out_value_reg <= act_val;
            final_reg     <= cmd.last_neuron;
        end
    end

    assign neuron    = neuron_reg;
    assign out_value = out_value_reg;
    assign final_res = final_reg;

endmodule

[rtl/dlf_checker.sv]
// Port-level assertions for the dense layer forward block, bound to the top level.
module dlf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [1:0]                 opcode,
    input logic                       last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [3:0]                 neuron,
    input logic signed [15:0]         out_value,
    input logic                       final_res
);

    // Loads are only taken between passes, never while a result is offered.
    a_no_load_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // A start element closes the input until the pass has finished.
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == dlf_pkg::OP_INPUT && last) |=> !in_ready)
        else $error("input still ready after the pass was started");

    // Transfer of the final result returns the block to loading.
    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_res) |=> (in_ready && !out_valid))
        else $error("block not idle after the final result");

    // Further neurons need a fresh MAC pass before the next result.
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !final_res) |=> (!out_valid && !in_ready))
        else $error("next result appeared without a MAC pass");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_value) && $stable(neuron) && $stable(final_res)))
        else $error("stalled result changed");

endmodule

bind dense_layer_forward dlf_checker u_dlf_checker (.*);

[dv/dense_layer_forward_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the dense layer forward block, with its own layer predictor.
module dense_layer_forward_tb;

    localparam int NIN          = 16;
    localparam int NOUT         = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int IDLE_CYCLES  = 8;
    localparam int MAX_REPORTS  = 10;

    // Codes that the package leaves without a name.
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] ACT_SPARE  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  opcode;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        last;
        bit          drain;
    } load_item_t;

    typedef struct {
        logic [3:0]         neuron;
        logic signed [15:0] act;
        logic               fin;
    } act_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                opcode = '0;
    logic [3:0]                row = '0;
    logic [3:0]                col = '0;
    logic signed [15:0]        value = '0;
    logic                      last = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [3:0]                neuron;
    logic signed [15:0]        out_value;
    logic                      final_res;
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_index = '0;
    logic [dlf_pkg::CNT_W-1:0] cfg_data = '0;

    // Shadow stores and registers of the predictor.
    logic signed [15:0]        w_mem [0:NOUT*NIN-1];
    logic signed [15:0]        b_mem [0:NOUT-1];
    logic signed [15:0]        x_mem [0:NIN-1];
    logic [dlf_pkg::CNT_W-1:0] cfg_in_r = 5'd1;
    logic [dlf_pkg::CNT_W-1:0] cfg_out_r = 5'd1;
    logic [1:0]                cfg_act_r = dlf_pkg::ACT_RELU;
    logic [15:0]               sig_lut [0:255];
    logic [15:0]               tanh_lut [0:255];

    // Entries the stimulus has written so far; a pass never reads anything else.
    bit w_seen [0:NOUT*NIN-1];
    bit b_seen [0:NOUT-1];
    bit x_seen [0:NIN-1];

    load_item_t  pending_loads [$];
    act_result_t expected_acts [$];

    bit          load_taken = 1'b0;
    int unsigned loads_outstanding = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned loads_done = 0;
    int unsigned passes_done = 0;
    int unsigned results_done = 0;
    int unsigned mismatches = 0;

    dense_layer_forward #(
        .IN_MAX  (NIN),
        .OUT_MAX (NOUT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .row       (row),
        .col       (col),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .neuron    (neuron),
        .out_value (out_value),
        .final_res (final_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int eff_in_count();
        if (cfg_in_r == '0)
            return 1;
        return (int'(cfg_in_r) > NIN) ? NIN : int'(cfg_in_r);
    endfunction

    function automatic int eff_out_count();
        int cap;
        cap = (NOUT < dlf_pkg::RES_LIMIT) ? NOUT : dlf_pkg::RES_LIMIT;
        if (cfg_out_r == '0)
            return 1;
        return (int'(cfg_out_r) > cap) ? cap : int'(cfg_out_r);
    endfunction

    function automatic longint saturate_acc(input longint a);
        if (a > 64'sd2147483647)
            return 64'sd2147483647;
        if (a < -64'sd2147483648)
            return -64'sd2147483648;
        return a;
    endfunction

    // Works out every neuron output of one layer pass from the shadow state.
    function automatic void predict_layer_pass();
        int          n_in;
        int          n_out;
        int          i;
        int          j;
        int          q;
        longint      acc;
        longint      pre;
        act_result_t res;
        n_in  = eff_in_count();
        n_out = eff_out_count();
        for (i = 0; i < n_out; i++)
        begin
            acc = 0;
            for (j = 0; j < n_in; j++)
            begin
                acc = saturate_acc(acc + longint'(w_mem[i*NIN+j]) * longint'(x_mem[j]));
            end
            acc = saturate_acc(acc + longint'(b_mem[i]) * 256);
            pre = acc >>> 8;
            if (pre > 32767)
                pre = 32767;
            else if (pre < -32768)
                pre = -32768;
            if (cfg_act_r == dlf_pkg::ACT_SIGMOID || cfg_act_r == dlf_pkg::ACT_TANH)
            begin
                q = int'(pre >>> 4);
                if (q > 127)
                    q = 127;
                else if (q < -128)
                    q = -128;
                res.act = (cfg_act_r == dlf_pkg::ACT_SIGMOID) ? sig_lut[q+128]
                                                              : tanh_lut[q+128];
            end
            else
            begin
                res.act = (pre > 0) ? pre[15:0] : 16'sd0;
            end
            res.neuron = i[3:0];
            res.fin    = (i == n_out - 1);
            expected_acts.push_back(res);
        end
        passes_done++;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = 16'($urandom_range(768)) - 16'd384;
            6, 7:             v = 16'($urandom());
            default:
            begin
                case ($urandom_range(3))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // Mostly an index inside the active part of the layer, now and then any index.
    function automatic logic [3:0] pick_index(input int n);
        if ($urandom_range(3) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(n - 1));
    endfunction

    task automatic queue_load(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                              input logic [15:0] v, input logic lst, input bit drain);
        load_item_t item;
        item.opcode = op;
        item.row    = r;
        item.col    = c;
        item.value  = v;
        item.last   = lst;
        item.drain  = drain;
        pending_loads.push_back(item);
        loads_outstanding++;
        case (op)
            dlf_pkg::OP_WEIGHT: w_seen[{r, c}] = 1'b1;
            dlf_pkg::OP_BIAS:   b_seen[r] = 1'b1;
            dlf_pkg::OP_INPUT:  x_seen[c] = 1'b1;
            default:            ;
        endcase
    endtask

    // Loads whatever the pass would read but has never been written, then the
    // input element that starts the pass.
    task automatic queue_pass(input logic [3:0] c, input logic [15:0] v, input bit drain);
        int n_in;
        int n_out;
        int i;
        int j;
        n_in  = eff_in_count();
        n_out = eff_out_count();
        for (i = 0; i < n_out; i++)
        begin
            for (j = 0; j < n_in; j++)
            begin
                if (!w_seen[i*NIN+j])
                    queue_load(dlf_pkg::OP_WEIGHT, i[3:0], j[3:0], pick_value(), 1'b0, 1'b0);
            end
            if (!b_seen[i])
                queue_load(dlf_pkg::OP_BIAS, i[3:0], 4'($urandom_range(15)), pick_value(),
                           1'b0, 1'b0);
        end
        for (j = 0; j < n_in; j++)
        begin
            if (!x_seen[j] && j != c)
                queue_load(dlf_pkg::OP_INPUT, 4'($urandom_range(15)), j[3:0], pick_value(),
                           1'b0, 1'b0);
        end
        queue_load(dlf_pkg::OP_INPUT, 4'($urandom_range(15)), c, v, 1'b1, drain);
    endtask

    task automatic random_burst(input int n);
        int k;
        int pick;
        int n_in;
        int n_out;
        n_in  = eff_in_count();
        n_out = eff_out_count();
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_load(dlf_pkg::OP_WEIGHT, pick_index(n_out), pick_index(n_in),
                           pick_value(), 1'($urandom_range(1)), 1'b0);
            else if (pick < 52)
                queue_load(dlf_pkg::OP_BIAS, pick_index(n_out), 4'($urandom_range(15)),
                           pick_value(), 1'($urandom_range(1)), 1'b0);
            else if (pick < 78)
                queue_load(dlf_pkg::OP_INPUT, 4'($urandom_range(15)), pick_index(n_in),
                           pick_value(), 1'b0, 1'b0);
            else if (pick < 92)
                queue_pass(pick_index(n_in), pick_value(), $urandom_range(3) == 0);
            else
                queue_load(OP_NONE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                           pick_value(), 1'($urandom_range(1)), 1'b0);
        end
        queue_pass(pick_index(n_in), pick_value(), 1'b0);
    endtask

    task automatic write_register(input logic [1:0] idx,
                                  input logic [dlf_pkg::CNT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            dlf_pkg::CFG_IN_COUNT:  cfg_in_r = data;
            dlf_pkg::CFG_OUT_COUNT: cfg_out_r = data;
            dlf_pkg::CFG_ACT_MODE:  cfg_act_r = data[1:0];
            default:                ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (loads_outstanding != 0 || expected_acts.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : load_monitor
        if (rst_n && in_valid && in_ready)
        begin
            load_taken = 1'b1;
            loads_outstanding--;
            loads_done++;
            case (opcode)
                dlf_pkg::OP_WEIGHT: w_mem[{row, col}] = value;
                dlf_pkg::OP_BIAS:   b_mem[row] = value;
                dlf_pkg::OP_INPUT:
                begin
                    x_mem[col] = value;
                    if (last)
                        predict_layer_pass();
                end
                default:            ;
            endcase
        end
    end

    always @(negedge clk)
    begin : load_driver
        load_item_t item;
        if (rst_n)
        begin
            if (!in_valid || load_taken)
            begin
                if (pending_loads.size() != 0
                    && !(pending_loads[0].drain && expected_acts.size() != 0)
                    && $urandom_range(99) >= send_gap_pct)
                begin
                    item = pending_loads.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= item.opcode;
                    row      <= item.row;
                    col      <= item.col;
                    value    <= item.value;
                    last     <= item.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            load_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        act_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_done++;
            if (expected_acts.size() == 0)
            begin
                note_mismatch($sformatf("result transfer for neuron %0d with none expected",
                                        neuron));
            end
            else
            begin
                want = expected_acts.pop_front();
                if (neuron !== want.neuron)
                    note_mismatch($sformatf("neuron expected %0d, got %0d",
                                            want.neuron, neuron));
                if (out_value !== want.act)
                    note_mismatch($sformatf("neuron %0d value expected %0d, got %0d",
                                            want.neuron, want.act, out_value));
                if (final_res !== want.fin)
                    note_mismatch($sformatf("neuron %0d final flag expected %0b, got %0b",
                                            want.neuron, want.fin, final_res));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding",
                     expected_acts.size());
            $display("dense_layer_forward_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        longint unsigned t;
        longint unsigned sum;
        longint unsigned b;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned mag;
        longint unsigned pw [0:256];
        int              k;
        int              q;
        int              m;
        int              j;

        // Activation tables in Q8.8 from powers of exp(-1/16) in Q30, taken from a short series.
        t   = 64'd1 << 40;
        sum = t;
        for (k = 1; k <= 12; k++)
        begin
            t = t / (64'd16 * 64'(k));
            if (k % 2 == 1)
                sum = sum - t;
            else
                sum = sum + t;
        end
        b     = (sum + (64'd1 << 9)) >> 10;
        pw[0] = 64'd1 << 30;
        for (k = 1; k <= 256; k++)
        begin
            pw[k] = (pw[k-1] * b + (64'd1 << 29)) >> 30;
        end
        for (k = 0; k < 256; k++)
        begin
            q   = k - 128;
            m   = (q < 0) ? -q : q;
            e   = pw[m];
            den = (64'd1 << 30) + e;
            num = (q >= 0) ? (64'd256 << 30) : 64'd256 * e;
            sig_lut[k] = 16'((2 * num + den) / (2 * den));
            e   = pw[2*m];
            den = (64'd1 << 30) + e;
            num = 64'd256 * ((64'd1 << 30) - e);
            mag = (2 * num + den) / (2 * den);
            tanh_lut[k] = (q < 0) ? -16'(mag) : 16'(mag);
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 29;
        recv_gap_pct = 70;

        // Reset settings: one input, one neuron, ReLU. Positive then negative saturation.
        queue_load(dlf_pkg::OP_WEIGHT, 4'd0, 4'd0, 16'h7FFF, 1'b0, 1'b0);
        queue_load(dlf_pkg::OP_BIAS, 4'd0, 4'd0, 16'h7FFF, 1'b1, 1'b0);
        queue_load(dlf_pkg::OP_INPUT, 4'd0, 4'd0, 16'h7FFF, 1'b1, 1'b0);
        queue_load(dlf_pkg::OP_WEIGHT, 4'd0, 4'd0, 16'h8000, 1'b1, 1'b1);
        queue_load(dlf_pkg::OP_INPUT, 4'd15, 4'd0, 16'h7FFF, 1'b1, 1'b0);
        queue_load(OP_NONE, 4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b0);
        wait_idle();

        // Four full-scale products overflow the accumulator.
        write_register(dlf_pkg::CFG_IN_COUNT, 5'd4);
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, dlf_pkg::ACT_TANH});
        for (j = 0; j < 4; j++)
            queue_load(dlf_pkg::OP_WEIGHT, 4'd0, j[3:0], 16'h8000, 1'b0, 1'b0);
        queue_load(dlf_pkg::OP_BIAS, 4'd0, 4'd9, 16'h0000, 1'b0, 1'b0);
        for (j = 0; j < 4; j++)
            queue_load(dlf_pkg::OP_INPUT, 4'd0, j[3:0], 16'h8000, j == 3, 1'b0);
        wait_idle();

        // A zero input count acts as one; the spare activation code acts as ReLU.
        write_register(dlf_pkg::CFG_IN_COUNT, 5'd0);
        write_register(dlf_pkg::CFG_OUT_COUNT, 5'd3);
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, dlf_pkg::ACT_SIGMOID});
        queue_load(dlf_pkg::OP_WEIGHT, 4'd1, 4'd0, 16'h8000, 1'b0, 1'b0);
        queue_load(dlf_pkg::OP_WEIGHT, 4'd2, 4'd0, 16'h0040, 1'b0, 1'b0);
        queue_load(dlf_pkg::OP_BIAS, 4'd1, 4'd0, 16'h8000, 1'b0, 1'b0);
        queue_load(dlf_pkg::OP_BIAS, 4'd2, 4'd0, 16'h0080, 1'b0, 1'b0);
        queue_pass(4'd0, 16'hFF00, 1'b0);
        wait_idle();
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, ACT_SPARE});
        queue_pass(4'd0, 16'h0100, 1'b0);
        wait_idle();

        write_register(dlf_pkg::CFG_IN_COUNT, 5'd3);
        write_register(dlf_pkg::CFG_OUT_COUNT, 5'd5);
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, dlf_pkg::ACT_RELU});
        random_burst(20);
        wait_idle();

        send_gap_pct = 70;
        recv_gap_pct = 29;
        write_register(dlf_pkg::CFG_IN_COUNT, 5'd16);
        write_register(dlf_pkg::CFG_OUT_COUNT, 5'd1);
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, dlf_pkg::ACT_SIGMOID});
        random_burst(16);
        wait_idle();
        write_register(dlf_pkg::CFG_IN_COUNT, 5'd1);
        write_register(dlf_pkg::CFG_OUT_COUNT, 5'd16);
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, dlf_pkg::ACT_TANH});
        random_burst(16);
        wait_idle();

        // No gaps; oversized counts clamp one at a time and the mode write is masked.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_register(CFG_UNUSED, 5'h1F);
        write_register(dlf_pkg::CFG_IN_COUNT, 5'd31);
        write_register(dlf_pkg::CFG_OUT_COUNT, 5'd1);
        write_register(dlf_pkg::CFG_ACT_MODE, 5'b11110);
        random_burst(12);
        wait_idle();
        write_register(dlf_pkg::CFG_IN_COUNT, 5'd1);
        write_register(dlf_pkg::CFG_OUT_COUNT, 5'd31);
        write_register(dlf_pkg::CFG_ACT_MODE, {3'b000, dlf_pkg::ACT_RELU});
        random_burst(12);
        wait_idle();
        repeat (20) @(negedge clk);

        $display("Covered %0d load transfers, %0d layer passes and %0d result transfers,",
                 loads_done, passes_done, results_done);
        $display("over ReLU, sigmoid and tanh with up to 16 inputs or 16 neurons, with gaps.");
        if (mismatches == 0 && expected_acts.size() == 0)
            $display("dense_layer_forward_tb OK");
        else
            $display("dense_layer_forward_tb NOT OK");
        $finish;
    end

endmodule
